>>> src/uart_rxf_pkg.sv
// ----------------------------------------------------------------------------
// uart_rxf_pkg
// shared types and constants of the 16550-style register file with rx fifo
// ----------------------------------------------------------------------------
package uart_rxf_pkg;

    localparam int RX_DEPTH_DEF = 16;

    // item kinds on the input channel
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RECV  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // register word offsets
    localparam logic [9:0] ADDR_RBR  = 10'h000;
    localparam logic [9:0] ADDR_IER  = 10'h001;
    localparam logic [9:0] ADDR_IIR  = 10'h002;
    localparam logic [9:0] ADDR_LCR  = 10'h003;
    localparam logic [9:0] ADDR_MCR  = 10'h004;
    localparam logic [9:0] ADDR_LSR  = 10'h005;
    localparam logic [9:0] ADDR_MSR  = 10'h006;
    localparam logic [9:0] ADDR_USR  = 10'h01f;
    localparam logic [9:0] ADDR_CPR  = 10'h03d;
    localparam logic [9:0] ADDR_UCV  = 10'h03e;
    localparam logic [9:0] ADDR_CTR  = 10'h03f;

    localparam logic [31:0] CPR_VALUE = 32'h0002_0002;
    localparam logic [31:0] UCV_VALUE = 32'h3230_312A;
    localparam logic [31:0] CTR_VALUE = 32'h4457_0110;

    // interrupt identity codes
    localparam logic [3:0] ID_NONE = 4'h1;
    localparam logic [3:0] ID_TX   = 4'h2;
    localparam logic [3:0] ID_RX   = 4'h4;

    localparam logic [7:0] LS_DR       = 8'h01;
    localparam logic [7:0] LS_OE       = 8'h02;
    localparam logic [7:0] LS_TX_EMPTY = 8'h60;
    localparam logic [7:0] LS_RESET    = 8'h60;
    localparam logic [7:0] US_RFNE     = 8'h08;
    localparam logic [7:0] US_RFF      = 8'h10;
    localparam logic [7:0] US_RESET    = 8'h06;

    localparam logic [31:0] DLH_RESET = 32'd4;

    // request from the register decode to the receive fifo
    typedef struct packed {
        logic       push;
        logic       load0;
        logic       pop;
        logic       flush;
        logic [7:0] data;
    } rxf_cmd_t;

    // one result item
    typedef struct packed {
        logic        rx_space;
        logic        rx_dma_req;
        logic        irq;
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic [31:0] rdata;
    } res_t;

endpackage

>>> src/uart_rxf_fifo.sv
// ----------------------------------------------------------------------------
// uart_rxf_fifo
// receive ring buffer with head pointer, fill count and per-entry valid bits
// ----------------------------------------------------------------------------
module uart_rxf_fifo #(
    parameter int RX_DEPTH = uart_rxf_pkg::RX_DEPTH_DEF,
    parameter int FILL_W   = $clog2(RX_DEPTH + 1),
    parameter int IDX_W    = $clog2(RX_DEPTH)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  uart_rxf_pkg::rxf_cmd_t cmd,
    output logic [FILL_W-1:0]     fill_reg,
    output logic [FILL_W-1:0]     fill_next,
    output logic [7:0]            head_data,
    output logic [7:0]            zero_data
);
    import uart_rxf_pkg::*;

    localparam int SUM_W = IDX_W + 1;

    logic [7:0]          store_reg [RX_DEPTH];
    logic [RX_DEPTH-1:0] valid_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    head_next;
    logic [SUM_W-1:0]    wr_sum;
    logic [IDX_W-1:0]    wr_idx;
    logic                do_push;
    logic                do_pop;

    assign do_push = cmd.push && (fill_reg < FILL_W'(RX_DEPTH));
    assign do_pop  = cmd.pop && (fill_reg != '0);

    // write slot is head plus fill, wrapped once
    always_comb begin
        wr_sum = SUM_W'(head_reg) + SUM_W'(fill_reg);
        if (wr_sum >= SUM_W'(RX_DEPTH)) begin
            wr_sum = wr_sum - SUM_W'(RX_DEPTH);
        end
        wr_idx = wr_sum[IDX_W-1:0];
    end

    always_comb begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (cmd.flush) begin
            head_next = '0;
            fill_next = '0;
        end else if (do_pop) begin
            head_next = (head_reg == IDX_W'(RX_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end else if (do_push) begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            fill_reg  <= '0;
            valid_reg <= '0;
        end else begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            if (do_push) begin
                valid_reg[wr_idx] <= 1'b1;
            end else if (cmd.load0) begin
                valid_reg[0] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_idx] <= cmd.data;
        end else if (cmd.load0) begin
            store_reg[0] <= cmd.data;
        end
    end

    // entries never written read as zero
    assign head_data = valid_reg[head_reg] ? store_reg[head_reg] : 8'h00;
    assign zero_data = valid_reg[0] ? store_reg[0] : 8'h00;

endmodule

>>> src/uart_rxf_regs.sv
// ----------------------------------------------------------------------------
// uart_rxf_regs
// register decode, control and status registers, interrupt identity
// ----------------------------------------------------------------------------
module uart_rxf_regs #(
    parameter int RX_DEPTH = uart_rxf_pkg::RX_DEPTH_DEF,
    parameter int FILL_W   = $clog2(RX_DEPTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic [1:0]             opcode,
    input  logic [9:0]             word_addr,
    input  logic [31:0]            wdata,
    input  logic [7:0]             rx_byte,
    input  logic [FILL_W-1:0]      fill_reg,
    input  logic [FILL_W-1:0]      fill_next,
    input  logic [7:0]             head_data,
    input  logic [7:0]             zero_data,
    output uart_rxf_pkg::rxf_cmd_t cmd,
    output uart_rxf_pkg::res_t     res
);
    import uart_rxf_pkg::*;

    logic [31:0] dll_reg, dll_next;
    logic [31:0] dlh_reg, dlh_next;
    logic [31:0] ier_reg, ier_next;
    logic [3:0]  iir_reg, iir_next;
    logic [31:0] fcr_reg, fcr_next;
    logic [31:0] lcr_reg, lcr_next;
    logic [31:0] mcr_reg, mcr_next;
    logic [7:0]  lsr_reg, lsr_next;
    logic [7:0]  usr_reg, usr_next;
    logic        dlab;
    logic        fifo_on;
    logic [31:0] rdata;
    logic        tx_valid;
    logic [7:0]  tx_byte;

    assign dlab    = lcr_reg[7];
    assign fifo_on = fcr_reg[0];

    always_comb begin
        dll_next = dll_reg;
        dlh_next = dlh_reg;
        ier_next = ier_reg;
        iir_next = iir_reg;
        fcr_next = fcr_reg;
        lcr_next = lcr_reg;
        mcr_next = mcr_reg;
        lsr_next = lsr_reg;
        usr_next = usr_reg;
        cmd      = '0;
        cmd.data = rx_byte;
        rdata    = '0;
        tx_valid = 1'b0;
        tx_byte  = '0;
        if (en) begin
            unique case (op_t'(opcode))
                OP_READ: begin
                    unique case (word_addr)
                        ADDR_RBR: begin
                            if (dlab) begin
                                rdata = dll_reg;
                            end else if (fifo_on) begin
                                rdata    = {24'd0, head_data};
                                cmd.pop  = 1'b1;
                                usr_next = usr_reg & ~US_RFF;
                                if (fill_reg <= FILL_W'(1)) begin
                                    lsr_next = lsr_reg & ~LS_DR;
                                    usr_next = usr_reg & ~(US_RFF | US_RFNE);
                                end
                                iir_next = ID_NONE;
                            end else begin
                                rdata    = {24'd0, zero_data};
                                usr_next = usr_reg & ~(US_RFF | US_RFNE);
                                lsr_next = lsr_reg & ~LS_DR;
                                iir_next = ID_NONE;
                            end
                        end
                        ADDR_IER: rdata = dlab ? dlh_reg : ier_reg;
                        ADDR_IIR: begin
                            rdata = {28'd0, iir_reg};
                            if (iir_reg == ID_TX) begin
                                iir_next = ID_NONE;
                            end
                        end
                        ADDR_LCR: rdata = lcr_reg;
                        ADDR_MCR: rdata = mcr_reg;
                        ADDR_LSR: rdata = {24'd0, lsr_reg};
                        ADDR_MSR: rdata = '0;
                        ADDR_USR: rdata = {24'd0, usr_reg};
                        ADDR_CPR: rdata = CPR_VALUE;
                        ADDR_UCV: rdata = UCV_VALUE;
                        ADDR_CTR: rdata = CTR_VALUE;
                        default:  rdata = '0;
                    endcase
                end
                OP_WRITE: begin
                    unique case (word_addr)
                        ADDR_RBR: begin
                            if (dlab) begin
                                dll_next = wdata;
                            end else begin
                                tx_valid = 1'b1;
                                tx_byte  = wdata[7:0];
                                lsr_next = lsr_reg | LS_TX_EMPTY;
                                if (iir_reg != ID_RX) begin
                                    iir_next = ID_TX;
                                end
                            end
                        end
                        ADDR_IER: begin
                            if (dlab) begin
                                dlh_next = wdata;
                            end else begin
                                ier_next = wdata;
                                iir_next = ID_TX;
                            end
                        end
                        ADDR_IIR: begin
                            fcr_next  = wdata;
                            cmd.flush = (fcr_reg[0] ^ wdata[0]) | wdata[1];
                        end
                        ADDR_LCR: lcr_next = wdata;
                        ADDR_MCR: mcr_next = wdata;
                        default: begin
                        end
                    endcase
                end
                OP_RECV: begin
                    if ((usr_reg & US_RFF) != '0) begin
                        lsr_next = lsr_reg | LS_OE;
                    end
                    if (!fifo_on) begin
                        cmd.load0 = 1'b1;
                        usr_next  = usr_reg | US_RFF | US_RFNE;
                    end else begin
                        cmd.push = 1'b1;
                        usr_next = usr_reg | US_RFNE;
                        if (fill_reg >= FILL_W'(RX_DEPTH - 1)) begin
                            usr_next = usr_reg | US_RFNE | US_RFF;
                        end
                    end
                    lsr_next = lsr_next | LS_DR;
                    iir_next = ID_RX;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        res            = '0;
        res.rdata      = rdata;
        res.tx_valid   = tx_valid;
        res.tx_byte    = tx_byte;
        res.irq        = ((iir_next == ID_TX) && ier_next[1]) ||
                         ((iir_next == ID_RX) && ier_next[0]);
        res.rx_dma_req = lsr_next[0];
        res.rx_space   = fcr_next[0] ? (fill_next < FILL_W'(RX_DEPTH))
                                     : (fill_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dll_reg <= '0;
            dlh_reg <= DLH_RESET;
            ier_reg <= '0;
            iir_reg <= ID_NONE;
            fcr_reg <= '0;
            lcr_reg <= '0;
            mcr_reg <= '0;
            lsr_reg <= LS_RESET;
            usr_reg <= US_RESET;
        end else begin
            dll_reg <= dll_next;
            dlh_reg <= dlh_next;
            ier_reg <= ier_next;
            iir_reg <= iir_next;
            fcr_reg <= fcr_next;
            lcr_reg <= lcr_next;
            mcr_reg <= mcr_next;
            lsr_reg <= lsr_next;
            usr_reg <= usr_next;
        end
    end

endmodule

>>> src/uart_register_block_rx_fifo_core.sv
// ----------------------------------------------------------------------------
// uart_register_block_rx_fifo_core
// 16550-style register file with receive fifo on a streaming item interface
// an accepted item's result is captured in the output register at the edge that accepts it
// throughput: one item per cycle while the output register is free or being taken; state updates in the accepting cycle
// the output register frees in the cycle its result is taken
// reset: synchronous active-low aresetn clears registers, fifo pointers and
// valid bits; the fifo store reads as zero until written
// ----------------------------------------------------------------------------
module uart_register_block_rx_fifo_core #(
    parameter int RX_DEPTH = uart_rxf_pkg::RX_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // word_addr[9:0], wdata[41:10], rx_byte[49:42], zero pad
    input  logic [1:0]  s_tuser,  // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // rdata[31:0], tx_valid[32], tx_byte[40:33], irq[41],
                                  // rx_dma_req[42], rx_space[43], zero pad
);
    import uart_rxf_pkg::*;

    localparam int FILL_W = $clog2(RX_DEPTH + 1);
    localparam int IDX_W  = $clog2(RX_DEPTH);

    logic              accept;
    logic              m_tvalid_reg;
    res_t              res;
    res_t              res_reg;
    rxf_cmd_t          cmd;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [7:0]        head_data;
    logic [7:0]        zero_data;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    uart_rxf_regs #(
        .RX_DEPTH (RX_DEPTH),
        .FILL_W   (FILL_W)
    ) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (accept),
        .opcode    (s_tuser),
        .word_addr (s_tdata[9:0]),
        .wdata     (s_tdata[41:10]),
        .rx_byte   (s_tdata[49:42]),
        .fill_reg  (fill_reg),
        .fill_next (fill_next),
        .head_data (head_data),
        .zero_data (zero_data),
        .cmd       (cmd),
        .res       (res)
    );

    uart_rxf_fifo #(
        .RX_DEPTH (RX_DEPTH),
        .FILL_W   (FILL_W),
        .IDX_W    (IDX_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .fill_reg  (fill_reg),
        .fill_next (fill_next),
        .head_data (head_data),
        .zero_data (zero_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, res_reg.rx_space, res_reg.rx_dma_req, res_reg.irq,
                       res_reg.tx_byte, res_reg.tx_valid, res_reg.rdata};

endmodule

>>> dv/uart_rxf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_rxf_checker
// Watches both channels of the uart register file. Every accepted input item
// runs through a local copy of the registers and the receive fifo, and the
// predicted result is queued. Every accepted result is compared field by
// field against the oldest queued one.
// ----------------------------------------------------------------------------
module uart_rxf_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,  // word_addr[9:0], wdata[41:10], rx_byte[49:42], zero pad
    input  logic [1:0]  s_tuser,  // opcode[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,  // rdata[31:0], tx_valid[32], tx_byte[40:33], irq[41],
                                  // rx_dma_req[42], rx_space[43], zero pad
    output int          fail_count,
    output int          pending_count
);
    import uart_rxf_pkg::*;

    localparam int          DEPTH      = RX_DEPTH_DEF;
    localparam logic [31:0] LC_DLAB    = 32'h80;
    localparam logic [31:0] FC_ENABLE  = 32'h1;
    localparam logic [31:0] FC_RX_RST  = 32'h2;
    localparam logic [31:0] IE_RX      = 32'h1;
    localparam logic [31:0] IE_TX      = 32'h2;

    logic [31:0] dll, dlh, ier, fcr, lcr, mcr;
    logic [3:0]  iir;
    logic [7:0]  lsr, usr;
    logic [7:0]  rx_ram [DEPTH];
    logic [3:0]  rd_ptr;
    logic [4:0]  fill_cnt;

    res_t awaited_results[$];
    int   errors = 0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic res_t regfile_result(op_t op, logic [9:0] addr, logic [31:0] wd,
                                            logic [7:0] rb);
        res_t r;
        r = '0;
        case (op)
            OP_READ: begin
                case (addr)
                    ADDR_RBR: begin
                        if ((lcr & LC_DLAB) != 0) begin
                            r.rdata = dll;
                        end else if ((fcr & FC_ENABLE) != 0) begin
                            usr &= ~US_RFF;
                            r.rdata = {24'h0, rx_ram[rd_ptr]};
                            if (fill_cnt > 0) begin
                                fill_cnt = fill_cnt - 1'b1;
                                rd_ptr = 4'((int'(rd_ptr) + 1) % DEPTH);
                            end
                            if (fill_cnt == 0) begin
                                lsr &= ~LS_DR;
                                usr &= ~US_RFNE;
                            end
                            iir = ID_NONE;
                        end else begin
                            usr &= ~(US_RFF | US_RFNE);
                            lsr &= ~LS_DR;
                            iir = ID_NONE;
                            r.rdata = {24'h0, rx_ram[0]};
                        end
                    end
                    ADDR_IER: r.rdata = ((lcr & LC_DLAB) != 0) ? dlh : ier;
                    ADDR_IIR: begin
                        r.rdata = {28'h0, iir};
                        if (iir == ID_TX) iir = ID_NONE;
                    end
                    ADDR_LCR: r.rdata = lcr;
                    ADDR_MCR: r.rdata = mcr;
                    ADDR_LSR: r.rdata = {24'h0, lsr};
                    ADDR_USR: r.rdata = {24'h0, usr};
                    ADDR_CPR: r.rdata = CPR_VALUE;
                    ADDR_UCV: r.rdata = UCV_VALUE;
                    ADDR_CTR: r.rdata = CTR_VALUE;
                    default: r.rdata = '0;
                endcase
            end
            OP_WRITE: begin
                case (addr)
                    ADDR_RBR: begin
                        if ((lcr & LC_DLAB) != 0) begin
                            dll = wd;
                        end else begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = wd[7:0];
                            lsr |= LS_TX_EMPTY;
                            if (iir != ID_RX) iir = ID_TX;
                        end
                    end
                    ADDR_IER: begin
                        if ((lcr & LC_DLAB) != 0) begin
                            dlh = wd;
                        end else begin
                            ier = wd;
                            iir = ID_TX;
                        end
                    end
                    ADDR_IIR: begin
                        if (((fcr ^ wd) & FC_ENABLE) != 0 || (wd & FC_RX_RST) != 0) begin
                            rd_ptr = '0;
                            fill_cnt = '0;
                        end
                        fcr = wd;
                    end
                    ADDR_LCR: lcr = wd;
                    ADDR_MCR: mcr = wd;
                    default: ;
                endcase
            end
            OP_RECV: begin
                if ((usr & US_RFF) != 0) lsr |= LS_OE;
                if ((fcr & FC_ENABLE) == 0) begin
                    rx_ram[0] = rb;
                    usr |= US_RFF | US_RFNE;
                end else begin
                    if (fill_cnt < DEPTH) begin
                        rx_ram[(int'(rd_ptr) + int'(fill_cnt)) % DEPTH] = rb;
                        fill_cnt = fill_cnt + 1'b1;
                    end
                    usr |= US_RFNE;
                    if (fill_cnt >= DEPTH) usr |= US_RFF;
                end
                lsr |= LS_DR;
                iir = ID_RX;
            end
            default: ;
        endcase
        r.irq = (iir == ID_TX && (ier & IE_TX) != 0) || (iir == ID_RX && (ier & IE_RX) != 0);
        r.rx_dma_req = (lsr & LS_DR) != 0;
        r.rx_space = ((fcr & FC_ENABLE) != 0) ? (fill_cnt < DEPTH) : (fill_cnt < 1);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("mismatch in %s: expected %h, got %h", field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        res_t got;
        if (!aresetn) begin
            dll      = '0;
            dlh      = DLH_RESET;
            ier      = '0;
            iir      = ID_NONE;
            fcr      = '0;
            lcr      = '0;
            mcr      = '0;
            lsr      = LS_RESET;
            usr      = US_RESET;
            rd_ptr   = '0;
            fill_cnt = '0;
            for (int i = 0; i < DEPTH; i++) rx_ram[i] = 8'h00;
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[43:0]);
                if (awaited_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("result with nothing awaited: %h", m_tdata);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("rdata", want.rdata, got.rdata);
                    check_field("tx_valid", want.tx_valid, got.tx_valid);
                    check_field("tx_byte", want.tx_byte, got.tx_byte);
                    check_field("irq", want.irq, got.irq);
                    check_field("rx_dma_req", want.rx_dma_req, got.rx_dma_req);
                    check_field("rx_space", want.rx_space, got.rx_space);
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(regfile_result(op_t'(s_tuser), s_tdata[9:0],
                                                         s_tdata[41:10], s_tdata[49:42]));
        end
        fail_count    <= errors;
        pending_count <= awaited_results.size();
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives register reads and writes and received bytes into the uart register
// file: a directed pass over every register and corner, then random traffic
// with fifo fill and drain bursts, random gaps on both sides and a stretch
// without gaps. The checker does all comparison; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import uart_rxf_pkg::*;

    localparam int N_ITEMS    = 400;
    localparam int QUIET_MAX  = 1000;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        steady   = 1'b0;

    int fail_count;
    int pending_count;
    int items_done  = 0;
    int quiet_cycles = 0;

    uart_register_block_rx_fifo_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    uart_rxf_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 37);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(input op_t op, input logic [9:0] addr, input logic [31:0] wd,
                             input logic [7:0] rb);
        while (!steady && $urandom_range(99) < 37) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'h0, rb, wd, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op != OP_NOP) items_done++;
    endtask

    function automatic logic [9:0] pick_addr();
        case ($urandom_range(13))
            0, 1:    return ADDR_RBR;
            2:       return ADDR_IER;
            3, 4:    return ADDR_IIR;
            5:       return ADDR_LCR;
            6:       return ADDR_MCR;
            7:       return ADDR_LSR;
            8:       return ADDR_MSR;
            9:       return ADDR_USR;
            10:      return ADDR_CPR;
            11:      return ADDR_UCV;
            12:      return ADDR_CTR;
            default: return 10'($urandom_range(1023));
        endcase
    endfunction

    initial begin
        logic [9:0]  addr;
        logic [31:0] wd;
        int          n;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // registers straight out of reset
        send_item(OP_READ, ADDR_RBR, 32'h0, 8'h00);
        send_item(OP_READ, ADDR_IER, 32'h0, 8'h00);
        send_item(OP_READ, ADDR_IIR, 32'h0, 8'h00);
        send_item(OP_READ, ADDR_LSR, 32'h0, 8'h00);
        send_item(OP_READ, ADDR_USR, 32'h0, 8'h00);
        send_item(OP_READ, ADDR_MSR, 32'h0, 8'h00);
        send_item(OP_READ, ADDR_CPR, 32'h0, 8'h00);
        send_item(OP_READ, ADDR_UCV, 32'h0, 8'h00);
        send_item(OP_READ, ADDR_CTR, 32'h0, 8'h00);
        send_item(OP_READ, 10'h3ff, 32'h0, 8'h00);
        send_item(OP_NOP, 10'h3ff, 32'hffff_ffff, 8'hff);
        // divisor latches
        send_item(OP_WRITE, ADDR_LCR, 32'h80, 8'h00);
        send_item(OP_WRITE, ADDR_RBR, 32'hffff_ffff, 8'h00);
        send_item(OP_WRITE, ADDR_IER, 32'h0, 8'h00);
        send_item(OP_READ, ADDR_RBR, 32'h0, 8'h00);
        send_item(OP_READ, ADDR_IER, 32'h0, 8'h00);
        send_item(OP_WRITE, ADDR_LCR, 32'h0, 8'h00);
        // tx interrupt and thr
        send_item(OP_WRITE, ADDR_IER, 32'hffff_ffff, 8'h00);
        send_item(OP_READ, ADDR_IIR, 32'h0, 8'h00);
        send_item(OP_WRITE, ADDR_RBR, 32'hffff_ffff, 8'h00);
        // non-fifo receive, overrun
        send_item(OP_RECV, 10'h0, 32'h0, 8'h00);
        send_item(OP_RECV, 10'h3ff, 32'hffff_ffff, 8'hff);
        send_item(OP_READ, ADDR_LSR, 32'h0, 8'h00);
        send_item(OP_READ, ADDR_RBR, 32'h0, 8'h00);
        // ignored write, fifo enable, flush
        send_item(OP_WRITE, 10'h3ff, 32'hffff_ffff, 8'h00);
        send_item(OP_WRITE, ADDR_IIR, 32'h1, 8'h00);
        send_item(OP_WRITE, ADDR_MCR, 32'hffff_ffff, 8'h00);
        send_item(OP_READ, ADDR_MCR, 32'h0, 8'h00);
        send_item(OP_WRITE, ADDR_IIR, 32'h3, 8'h00);

        while (items_done < N_ITEMS) begin
            steady <= (items_done >= 200 && items_done < 280);
            case ($urandom_range(9))
                0, 1: begin
                    // fill the fifo, often past full, then drain it
                    n = $urandom_range(20, 4);
                    repeat (n) send_item(OP_RECV, 10'($urandom_range(1023)), $urandom,
                                         8'($urandom_range(255)));
                    n = $urandom_range(20, 1);
                    repeat (n) send_item(OP_READ, ADDR_RBR, $urandom,
                                         8'($urandom_range(255)));
                end
                2, 3: send_item(OP_RECV, 10'($urandom_range(1023)), $urandom,
                                8'($urandom_range(255)));
                4, 5: send_item(OP_READ, pick_addr(), $urandom, 8'($urandom_range(255)));
                6, 7, 8: begin
                    addr = pick_addr();
                    wd = $urandom;
                    if (addr == ADDR_LCR) wd[7] = ($urandom_range(99) < 15);
                    if (addr == ADDR_IIR) begin
                        wd[0] = ($urandom_range(99) < 80);
                        wd[1] = ($urandom_range(99) < 10);
                    end
                    send_item(OP_WRITE, addr, wd, 8'($urandom_range(255)));
                end
                default: send_item(op_t'($urandom_range(3)), 10'($urandom_range(1023)),
                                   $urandom, 8'($urandom_range(255)));
            endcase
        end
        s_tvalid <= 1'b0;
        steady   <= 1'b0;

        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
